// ===== rtl/median_moisture_pump_controller_macros.svh =====
// Assertion macros shared by the median moisture pump controller RTL.
`ifndef MEDIAN_MOISTURE_PUMP_CONTROLLER_MACROS_SVH
`define MEDIAN_MOISTURE_PUMP_CONTROLLER_MACROS_SVH

// Clocked on clock, quiet during reset.
`define MMPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked on clock, also checked during reset.
`define MMPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/mmpc_pkg.sv =====
// Types, constants and register map of the median moisture pump controller.
package mmpc_pkg;

   localparam int SAMPLES_DEF = 15;

   localparam int SAMPLE_W  = 12;
   localparam int TIME_W    = 32;
   localparam int PCT_W     = 7;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;

   localparam int PCT_SCALE = 100;
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   // divider: magnitude of (raw - dry) * 100 fits in 19 bits
   localparam int NUM_W     = 19;
   localparam int DIV_STEPS = NUM_W;
   localparam int CNT_W     = 5;

   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_DRY_RAW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_RAW    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ON     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_OFF    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ON     = 3'd6;

   localparam logic [SAMPLE_W-1:0] DRY_RAW_RST  = 12'd3300;
   localparam logic [SAMPLE_W-1:0] WET_RAW_RST  = 12'd1500;
   localparam logic [PCT_W-1:0]    LOW_THR_RST  = 7'd35;
   localparam logic [PCT_W-1:0]    HIGH_THR_RST = 7'd60;
   localparam logic [TIME_W-1:0]   MIN_ON_RST   = 32'd15000;
   localparam logic [TIME_W-1:0]   MIN_OFF_RST  = 32'd10000;
   localparam logic [TIME_W-1:0]   MAX_ON_RST   = 32'd600000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] dry_raw;
      logic [SAMPLE_W-1:0] wet_raw;
      logic [PCT_W-1:0]    low_threshold_pct;
      logic [PCT_W-1:0]    high_threshold_pct;
      logic [TIME_W-1:0]   min_on_ms;
      logic [TIME_W-1:0]   min_off_ms;
      logic [TIME_W-1:0]   max_on_ms;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] median;
      logic [TIME_W-1:0]   now_ms;
   } job_type;

endpackage

// ===== rtl/mmpc_front.sv =====
// Front end: takes samples into a sorted window and queues the median per window.
module mmpc_front #(
   parameter int SAMPLES = mmpc_pkg::SAMPLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mmpc_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [mmpc_pkg::TIME_W-1:0]   req_now_ms,
   output logic                          push_valid,
   input  logic                          push_ready,
   output mmpc_pkg::job_type             push_job
);
   import mmpc_pkg::*;

   localparam int FW  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int MID = SAMPLES / 2;

   logic [SAMPLE_W-1:0] sorted_ff [SAMPLES];
   logic [SAMPLE_W-1:0] sorted_in [SAMPLES];
   logic [FW-1:0]       fill_ff;
   logic [FW-1:0]       fill_in;
   logic [SAMPLES-1:0]  keep;
   logic                last_slot;
   logic                accept;

   assign last_slot  = (fill_ff == FW'(SAMPLES - 1));
   assign req_ready  = push_ready || !last_slot;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept && last_slot;

   // one insertion step: entries at or below the new sample stay, the rest move up
   for (genvar k = 0; k < SAMPLES; k++) begin : g_cell
      assign keep[k] = (fill_ff > FW'(k)) && (sorted_ff[k] <= req_sample);
      if (k == 0) begin : g_first
         assign sorted_in[k] = keep[k] ? sorted_ff[k] : req_sample;
      end else begin : g_rest
         assign sorted_in[k] = keep[k]     ? sorted_ff[k] :
                               keep[k - 1] ? req_sample   : sorted_ff[k - 1];
      end
   end

   assign push_job.median = sorted_in[MID];
   assign push_job.now_ms = req_now_ms;

   assign fill_in = last_slot ? '0 : fill_ff + FW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sorted_ff <= sorted_in;
      end
   end

endmodule

// ===== rtl/mmpc_queue.sv =====
// Two-entry queue between the window front end and the pump back end.
module mmpc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mmpc_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mmpc_pkg::job_type pop_job
);
   import mmpc_pkg::*;

   job_type         entry_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff;
   logic [Q_AW-1:0] rd_ptr_ff;
   logic [Q_AW:0]   count_ff;
   logic [Q_AW:0]   count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != (Q_AW + 1)'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + (Q_AW + 1)'(1);
         2'b01:   count_in = count_ff - (Q_AW + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/mmpc_back.sv =====
// Back end: percent conversion by serial division, pump decision and result register.
module mmpc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  mmpc_pkg::cfg_type             cfg,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  mmpc_pkg::job_type             pop_job,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mmpc_pkg::SAMPLE_W-1:0] rsp_median_raw,
   output logic [mmpc_pkg::PCT_W-1:0]    rsp_moisture_pct,
   output logic                          rsp_pump_on,
   output logic                          rsp_forced_off
);
   import mmpc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIV    = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [SAMPLE_W-1:0] rem_ff;
   logic [NUM_W-1:0]    dq_ff;
   logic [SAMPLE_W-1:0] den_ff;
   logic                zero_ff;
   logic [SAMPLE_W-1:0] med_ff;
   logic [TIME_W-1:0]   now_ff;
   logic                pump_ff;
   logic [TIME_W-1:0]   last_change_ff;
   logic [TIME_W-1:0]   on_start_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_median_ff;
   logic [PCT_W-1:0]    rsp_pct_ff;
   logic                rsp_pump_ff;
   logic                rsp_forced_ff;

   // operand setup
   logic [SAMPLE_W:0]   diff;
   logic [SAMPLE_W:0]   den;
   logic [SAMPLE_W:0]   diff_neg;
   logic [SAMPLE_W:0]   den_neg;
   logic [SAMPLE_W-1:0] diff_mag;
   logic [SAMPLE_W-1:0] den_mag;
   logic [NUM_W-1:0]    num_mag;
   logic                quot_zero;

   // division step
   logic [SAMPLE_W:0]   shifted;
   logic [SAMPLE_W+1:0] trial;
   logic                ge;

   // decision
   logic [PCT_W-1:0]    pct;
   logic                forced;
   logic                pump_mid;
   logic                off_long_enough;
   logic                on_long_enough;
   logic                go_on;
   logic                go_off;
   logic                pump_in;
   logic                pop_fire;
   logic                decide_fire;

   assign pop_ready   = (state_ff == ST_IDLE);
   assign pop_fire    = pop_valid && pop_ready;
   assign decide_fire = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_ready);

   assign diff     = {1'b0, pop_job.median} - {1'b0, cfg.dry_raw};
   assign den      = {1'b0, cfg.wet_raw} - {1'b0, cfg.dry_raw};
   assign diff_neg = -diff;
   assign den_neg  = -den;
   assign diff_mag = diff[SAMPLE_W] ? diff_neg[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];
   assign den_mag  = den[SAMPLE_W] ? den_neg[SAMPLE_W-1:0] : den[SAMPLE_W-1:0];
   assign num_mag  = NUM_W'(diff_mag) * NUM_W'(PCT_SCALE);
   // opposite signs truncate to zero or below, which clamps to zero
   assign quot_zero = (den == '0) || (diff == '0) || (diff[SAMPLE_W] != den[SAMPLE_W]);

   assign shifted = {rem_ff, dq_ff[NUM_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};
   assign ge      = !trial[SAMPLE_W+1];

   assign pct = zero_ff                       ? '0      :
                (dq_ff > NUM_W'(PCT_SCALE))   ? PCT_MAX : dq_ff[PCT_W-1:0];

   assign forced          = pump_ff && ((now_ff - on_start_ff) >= cfg.max_on_ms);
   assign pump_mid        = pump_ff && !forced;
   assign off_long_enough = forced ? (cfg.min_off_ms == '0)
                                   : ((now_ff - last_change_ff) >= cfg.min_off_ms);
   assign on_long_enough  = (now_ff - last_change_ff) >= cfg.min_on_ms;
   assign go_on           = !pump_mid && off_long_enough && (pct <= cfg.low_threshold_pct);
   assign go_off          = pump_mid && on_long_enough && (pct >= cfg.high_threshold_pct);
   assign pump_in         = go_on ? 1'b1 : (go_off ? 1'b0 : pump_mid);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (pop_fire) state_in = ST_DIV;
         ST_DIV:    if (cnt_ff == CNT_W'(1)) state_in = ST_DECIDE;
         ST_DECIDE: if (decide_fire) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pump_ff        <= 1'b0;
         last_change_ff <= '0;
         on_start_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (decide_fire) begin
            pump_ff      <= pump_in;
            rsp_valid_ff <= 1'b1;
            if (forced || go_on || go_off) begin
               last_change_ff <= now_ff;
            end
            if (go_on) begin
               on_start_ff <= now_ff;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_fire) begin
         cnt_ff  <= CNT_W'(DIV_STEPS);
         rem_ff  <= '0;
         dq_ff   <= num_mag;
         den_ff  <= den_mag;
         zero_ff <= quot_zero;
         med_ff  <= pop_job.median;
         now_ff  <= pop_job.now_ms;
      end else if (state_ff == ST_DIV) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         rem_ff <= ge ? trial[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
         dq_ff  <= {dq_ff[NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (decide_fire) begin
         rsp_median_ff <= med_ff;
         rsp_pct_ff    <= pct;
         rsp_pump_ff   <= pump_in;
         rsp_forced_ff <= forced;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_raw   = rsp_median_ff;
   assign rsp_moisture_pct = rsp_pct_ff;
   assign rsp_pump_on      = rsp_pump_ff;
   assign rsp_forced_off   = rsp_forced_ff;

endmodule

// ===== rtl/median_moisture_pump_controller.sv =====
// Median-filtered soil moisture pump controller, top level.
//
// Requests carry one 12-bit ADC sample and its millisecond timestamp on a
// valid/ready channel. Every SAMPLES-th request closes a window; the median
// of that window is converted to percent and drives the pump decision, and
// one response (median, percent, pump state, forced-off flag) comes out on
// the rsp_ channel. Other requests produce no response.
// Requests are taken one per cycle. The request that closes a window is
// taken only while the two-entry job queue has room.
// From the closing request to rsp_valid a job leaves the queue, passes the
// bit-serial percent divider and then the registered decision step.
// The back end takes a new window only from idle, after finishing the last;
// when windows close faster, they are absorbed by the queue and then throttle
// the closing request.
// A stalled response holds in the output register; the back end finishes
// its current window and waits, while the front end keeps filling.
// Reset empties the window and queue, turns the pump off, zeroes both
// timestamps and loads the default calibration; csr_ writes take effect at once.
`include "median_moisture_pump_controller_macros.svh"

module median_moisture_pump_controller #(
   parameter int SAMPLES = mmpc_pkg::SAMPLES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mmpc_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [mmpc_pkg::TIME_W-1:0]    req_now_ms,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mmpc_pkg::SAMPLE_W-1:0]  rsp_median_raw,
   output logic [mmpc_pkg::PCT_W-1:0]     rsp_moisture_pct,
   output logic                           rsp_pump_on,
   output logic                           rsp_forced_off,
   input  logic                           csr_we,
   input  logic [mmpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mmpc_pkg::CSR_W-1:0]     csr_wdata
);
   import mmpc_pkg::*;

   cfg_type cfg_ff;
   logic    q_push_valid;
   logic    q_push_ready;
   job_type q_push_job;
   logic    q_pop_valid;
   logic    q_pop_ready;
   job_type q_pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dry_raw            <= DRY_RAW_RST;
         cfg_ff.wet_raw            <= WET_RAW_RST;
         cfg_ff.low_threshold_pct  <= LOW_THR_RST;
         cfg_ff.high_threshold_pct <= HIGH_THR_RST;
         cfg_ff.min_on_ms          <= MIN_ON_RST;
         cfg_ff.min_off_ms         <= MIN_OFF_RST;
         cfg_ff.max_on_ms          <= MAX_ON_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DRY_RAW:  cfg_ff.dry_raw            <= csr_wdata[SAMPLE_W-1:0];
            CSR_WET_RAW:  cfg_ff.wet_raw            <= csr_wdata[SAMPLE_W-1:0];
            CSR_LOW_THR:  cfg_ff.low_threshold_pct  <= csr_wdata[PCT_W-1:0];
            CSR_HIGH_THR: cfg_ff.high_threshold_pct <= csr_wdata[PCT_W-1:0];
            CSR_MIN_ON:   cfg_ff.min_on_ms          <= csr_wdata[TIME_W-1:0];
            CSR_MIN_OFF:  cfg_ff.min_off_ms         <= csr_wdata[TIME_W-1:0];
            CSR_MAX_ON:   cfg_ff.max_on_ms          <= csr_wdata[TIME_W-1:0];
            default:      cfg_ff                    <= cfg_ff;
         endcase
      end
   end

   mmpc_front #(
      .SAMPLES (SAMPLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_now_ms (req_now_ms),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_job   (q_push_job)
   );

   mmpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_job   (q_push_job),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_job    (q_pop_job)
   );

   mmpc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (q_pop_valid),
      .pop_ready        (q_pop_ready),
      .pop_job          (q_pop_job),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_raw   (rsp_median_raw),
      .rsp_moisture_pct (rsp_moisture_pct),
      .rsp_pump_on      (rsp_pump_on),
      .rsp_forced_off   (rsp_forced_off)
   );

   `MMPC_ASSERT(a_push_has_room, q_push_valid |-> q_push_ready, "window median pushed into a full queue")
   `MMPC_ASSERT(a_pct_range, rsp_valid |-> (rsp_moisture_pct <= PCT_MAX), "moisture percent above 100")
   `MMPC_ASSERT(a_forced_reon, (rsp_valid && rsp_forced_off && rsp_pump_on) |-> (cfg_ff.min_off_ms == '0), "pump back on after forced off with nonzero min off time")

endmodule

// ===== dv/median_moisture_pump_controller_tb.sv =====
// Testbench for the median moisture pump controller: sample windows checked against a predictor.
module median_moisture_pump_controller_tb;
   import mmpc_pkg::*;

   localparam int SAMPLES      = SAMPLES_DEF;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] median_raw;
      logic [PCT_W-1:0]    moisture_pct;
      logic                pump_on;
      logic                forced_off;
   } reading_type;

   class pump_scoreboard;
      cfg_type             cfg;
      logic [SAMPLE_W-1:0] window [SAMPLES];
      int                  fill;
      logic                pump;
      logic [TIME_W-1:0]   last_change;
      logic [TIME_W-1:0]   on_start;
      reading_type         expected_readings [$];
      int                  failures;
      int                  windows_checked;
      int                  samples_seen;
      int                  turned_on;
      int                  turned_off;
      int                  forced_offs;

      function new();
         cfg.dry_raw            = DRY_RAW_RST;
         cfg.wet_raw            = WET_RAW_RST;
         cfg.low_threshold_pct  = LOW_THR_RST;
         cfg.high_threshold_pct = HIGH_THR_RST;
         cfg.min_on_ms          = MIN_ON_RST;
         cfg.min_off_ms         = MIN_OFF_RST;
         cfg.max_on_ms          = MAX_ON_RST;
         fill            = 0;
         pump            = 1'b0;
         last_change     = '0;
         on_start        = '0;
         failures        = 0;
         windows_checked = 0;
         samples_seen    = 0;
         turned_on       = 0;
         turned_off      = 0;
         forced_offs     = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] value);
         case (index)
            CSR_DRY_RAW:  cfg.dry_raw            = value[SAMPLE_W-1:0];
            CSR_WET_RAW:  cfg.wet_raw            = value[SAMPLE_W-1:0];
            CSR_LOW_THR:  cfg.low_threshold_pct  = value[PCT_W-1:0];
            CSR_HIGH_THR: cfg.high_threshold_pct = value[PCT_W-1:0];
            CSR_MIN_ON:   cfg.min_on_ms          = value[TIME_W-1:0];
            CSR_MIN_OFF:  cfg.min_off_ms         = value[TIME_W-1:0];
            CSR_MAX_ON:   cfg.max_on_ms          = value[TIME_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [SAMPLE_W-1:0] window_median();
         logic [SAMPLE_W-1:0] s [SAMPLES];
         logic [SAMPLE_W-1:0] v;
         int j;
         s = window;
         for (int i = 1; i < SAMPLES; i++) begin
            v = s[i];
            j = i - 1;
            while (j >= 0) begin
               if (s[j] <= v) break;
               s[j + 1] = s[j];
               j--;
            end
            s[j + 1] = v;
         end
         return s[SAMPLES / 2];
      endfunction

      function logic [PCT_W-1:0] percent_of(logic [SAMPLE_W-1:0] raw);
         int num;
         int den;
         int q;
         num = (int'(raw) - int'(cfg.dry_raw)) * PCT_SCALE;
         den = int'(cfg.wet_raw) - int'(cfg.dry_raw);
         if (den == 0) return '0;
         q = num / den;
         if (q < 0) q = 0;
         if (q > int'(PCT_MAX)) q = int'(PCT_MAX);
         return q[PCT_W-1:0];
      endfunction

      // one accepted request; a full window yields one expected reading
      function void note_sample(logic [SAMPLE_W-1:0] sample, logic [TIME_W-1:0] now);
         reading_type         r;
         logic [SAMPLE_W-1:0] med;
         logic [PCT_W-1:0]    pct;
         logic [TIME_W-1:0]   on_time;
         logic [TIME_W-1:0]   since_change;
         samples_seen++;
         window[fill] = sample;
         fill++;
         if (fill < SAMPLES) return;
         fill = 0;
         med = window_median();
         pct = percent_of(med);
         r.forced_off = 1'b0;
         on_time = now - on_start;
         if (pump && on_time >= cfg.max_on_ms) begin
            pump         = 1'b0;
            last_change  = now;
            r.forced_off = 1'b1;
            forced_offs++;
         end
         since_change = now - last_change;
         if (!pump && since_change >= cfg.min_off_ms && pct <= cfg.low_threshold_pct) begin
            pump        = 1'b1;
            last_change = now;
            on_start    = now;
            turned_on++;
         end else if (pump && since_change >= cfg.min_on_ms &&
                      pct >= cfg.high_threshold_pct) begin
            pump        = 1'b0;
            last_change = now;
            turned_off++;
         end
         r.median_raw   = med;
         r.moisture_pct = pct;
         r.pump_on      = pump;
         expected_readings.push_back(r);
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected response: median %0d pct %0d pump %0b forced %0b",
                        got.median_raw, got.moisture_pct, got.pump_on, got.forced_off);
            return;
         end
         want = expected_readings.pop_front();
         windows_checked++;
         if (got.median_raw !== want.median_raw || got.moisture_pct !== want.moisture_pct ||
             got.pump_on !== want.pump_on || got.forced_off !== want.forced_off) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("window %0d: expected median %0d pct %0d pump %0b forced %0b, got %s",
                        windows_checked, want.median_raw, want.moisture_pct, want.pump_on,
                        want.forced_off,
                        $sformatf("median %0d pct %0d pump %0b forced %0b", got.median_raw,
                                  got.moisture_pct, got.pump_on, got.forced_off));
         end
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_sample = '0;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_median_raw;
   logic [PCT_W-1:0]     rsp_moisture_pct;
   logic                 rsp_pump_on;
   logic                 rsp_forced_off;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   reading_type          rsp_reading;

   pump_scoreboard sb = new();

   logic [TIME_W-1:0]   stamp_ms = '0;
   bit                  req_rush = 1'b0;
   bit                  rsp_rush = 1'b0;
   int                  rsp_hold = 0;
   int                  idle_cycles = 0;
   int                  phases = 0;
   logic [SAMPLE_W-1:0] directed_samples [15] = '{
      12'd0, 12'd4095, 12'd0, 12'd4095, 12'd2700, 12'd4094, 12'd2700, 12'd2700,
      12'd2700, 12'd3300, 12'd4095, 12'd2700, 12'd2701, 12'd1, 12'd2699
   };

   median_moisture_pump_controller i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_median_raw   (rsp_median_raw),
      .rsp_moisture_pct (rsp_moisture_pct),
      .rsp_pump_on      (rsp_pump_on),
      .rsp_forced_off   (rsp_forced_off),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   assign rsp_reading = {rsp_median_raw, rsp_moisture_pct, rsp_pump_on, rsp_forced_off};

   always #2 clock = ~clock;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [TIME_W-1:0] rand_ms();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 600);
      return $urandom;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_reading(rsp_reading);
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_hold = rsp_rush ? 0 : idle_len();
         rsp_ready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("no request or response moved for %0d cycles", STALL_LIMIT);
         $display("median_moisture_pump_controller test failed");
         $finish;
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] sample,
                              input logic [TIME_W-1:0] now);
      int gap;
      gap = req_rush ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      req_now_ms <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(sample, now);
   endtask

   task automatic send_window(input int step_max);
      int pick;
      int frac;
      int span;
      int level;
      int spread;
      int value;
      pick = $urandom_range(0, 4);
      span = int'(sb.cfg.wet_raw) - int'(sb.cfg.dry_raw);
      case (pick)
         0: frac = int'(sb.cfg.low_threshold_pct) + int'($urandom_range(0, 6)) - 3;
         1: frac = int'(sb.cfg.high_threshold_pct) + int'($urandom_range(0, 6)) - 3;
         2: frac = int'($urandom_range(0, 1)) * 100 + int'($urandom_range(0, 10)) - 5;
         default: frac = int'($urandom_range(0, 120)) - 10;
      endcase
      level  = int'(sb.cfg.dry_raw) + span * frac / 100;
      spread = $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 60));
      for (int i = 0; i < SAMPLES; i++) begin
         if (pick == 4 || $urandom_range(0, 9) == 0)
            value = $urandom_range(0, 4095);
         else
            value = level + int'($urandom_range(0, 2 * spread)) - spread;
         if (value < 0) value = 0;
         if (value > 4095) value = 4095;
         if ($urandom_range(0, 49) == 0) stamp_ms = stamp_ms + $urandom;
         else stamp_ms = stamp_ms + $urandom_range(0, step_max);
         send_sample(value[SAMPLE_W-1:0], stamp_ms);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value,
                            input int width, input bit junk);
      logic [CSR_W-1:0] word;
      word = value;
      if (junk && width < CSR_W) word = value | ($urandom << width);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= word;
      @(posedge clock);
      sb.set_reg(index, word);
   endtask

   // all registers are rewritten once the back end has drained
   task automatic run_phase(input logic [SAMPLE_W-1:0] dry, wet,
                            input logic [PCT_W-1:0] low, high,
                            input logic [TIME_W-1:0] min_on, min_off, max_on,
                            input bit junk, input int windows, input int step_max);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_DRY_RAW, CSR_W'(dry), SAMPLE_W, junk);
      write_reg(CSR_WET_RAW, CSR_W'(wet), SAMPLE_W, junk);
      write_reg(CSR_LOW_THR, CSR_W'(low), PCT_W, junk);
      write_reg(CSR_HIGH_THR, CSR_W'(high), PCT_W, junk);
      write_reg(CSR_MIN_ON, min_on, TIME_W, junk);
      write_reg(CSR_MIN_OFF, min_off, TIME_W, junk);
      write_reg(CSR_MAX_ON, max_on, TIME_W, junk);
      csr_we <= 1'b0;
      req_rush = ($urandom_range(0, 3) == 0);
      rsp_rush = ($urandom_range(0, 3) == 0);
      phases++;
      repeat (windows) send_window(step_max);
   endtask

   initial begin
      logic [SAMPLE_W-1:0] dry;
      logic [SAMPLE_W-1:0] wet;
      logic [PCT_W-1:0]    low;
      logic [PCT_W-1:0]    high;
      int                  step_max;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset calibration; pump switches on exactly at the minimum off time
      for (int i = 0; i < SAMPLES; i++) begin
         if (i == 0) stamp_ms = '0;
         else if (i == 1) stamp_ms = 32'hFFFF_FFFF;
         else if (i == SAMPLES - 1) stamp_ms = 32'd10000;
         else stamp_ms = stamp_ms + 32'd7;
         send_sample(directed_samples[i], stamp_ms);
      end

      run_phase(12'd3300, 12'd1500, 7'd35, 7'd60, 32'd60, 32'd40, 32'd500, 1'b0, 10, 40);
      run_phase(12'd0, 12'd4095, 7'd0, 7'd100, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 8, 200);
      run_phase(12'd4095, 12'd0, 7'd100, 7'd0, 32'hFFFF_FFFF, 32'd0, 32'd300, 1'b0, 8, 40);
      // equal calibration
      run_phase(12'd2000, 12'd2000, 7'd0, 7'd127, 32'd5, 32'hFFFF_FFFF, 32'd100, 1'b0, 6, 40);
      // forced off and back on in the same decision
      run_phase(12'd3000, 12'd1000, 7'd127, 7'd127, 32'd0, 32'd0, 32'd0, 1'b0, 8, 3);
      // thresholds above 100, tiny time steps to land on dwell limits
      run_phase(12'd3300, 12'd1500, 7'd110, 7'd120, 32'd20, 32'd20, 32'd400, 1'b0, 6, 3);

      repeat (6) begin
         if ($urandom_range(0, 1)) begin
            dry = SAMPLE_W'($urandom_range(2500, 4095));
            wet = SAMPLE_W'($urandom_range(0, 2000));
         end else begin
            dry = SAMPLE_W'($urandom_range(0, 4095));
            wet = ($urandom_range(0, 4) == 0) ? dry : SAMPLE_W'($urandom_range(0, 4095));
         end
         low  = ($urandom_range(0, 9) == 0) ? PCT_W'($urandom_range(101, 127))
                                            : PCT_W'($urandom_range(0, 100));
         high = ($urandom_range(0, 9) == 0) ? PCT_W'($urandom_range(101, 127))
                                            : PCT_W'($urandom_range(0, 100));
         case ($urandom_range(0, 2))
            0: step_max = 3;
            1: step_max = 40;
            default: step_max = 200;
         endcase
         run_phase(dry, wet, low, high, rand_ms(), rand_ms(), rand_ms(),
                   bit'($urandom_range(0, 1)), 6, step_max);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests through %0d register settings, %0d windows checked, %0d bad.",
               sb.samples_seen, phases + 1, sb.windows_checked, sb.failures);
      $display("Pump switched on %0d times, off %0d times, forced off %0d times.",
               sb.turned_on, sb.turned_off, sb.forced_offs);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("median_moisture_pump_controller test passed");
      else
         $display("median_moisture_pump_controller test failed");
      $finish;
   end

endmodule
